// ===== rtl/core/line_framer_with_line_queue_assert.svh =====
// Assertion macros used by the line framer datapath.
`ifndef LINE_FRAMER_WITH_LINE_QUEUE_ASSERT_SVH
`define LINE_FRAMER_WITH_LINE_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LFQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lfq_pkg.sv =====
// Shared constants and controller/datapath interface types for the line framer.
`timescale 1ns / 1ps
package lfq_pkg;

    localparam int LINE_MAX_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] OP_RX   = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_LINK = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;
    localparam logic [1:0] KIND_DOWN = 2'd3;

    localparam logic [7:0] BYTE_NL = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    typedef struct packed {
        logic rx;           // receive byte item accepted
        logic link;         // link-down item accepted
        logic pop_accept;   // pop item accepted, latch capacity
        logic take_line;    // remove oldest line, latch its length
        logic emit_status;  // emit no-line / link-down result
        logic emit_zero;    // emit zero-length result
        logic emit_byte;    // emit one line byte
    } t_cmd;

    typedef struct packed {
        logic empty;        // no line queued
        logic len_zero;     // popped line truncated to nothing
        logic byte_last;    // current byte is the final one
        logic out_free;     // output register can take a result
    } t_sts;

endpackage

// ===== rtl/core/lfq_ctrl.sv =====
// Controller state machine: item acceptance and pop sequencing.
`timescale 1ns / 1ps
module lfq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    output logic          o_in_ready,
    input  lfq_pkg::t_sts i_sts,
    output lfq_pkg::t_cmd o_cmd
);
    import lfq_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_BYTES = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_RX:   o_cmd.rx = 1'b1;
                        OP_LINK: o_cmd.link = 1'b1;
                        OP_POP: begin
                            o_cmd.pop_accept = 1'b1;
                            n_state = ST_START;
                        end
                        default: ;
                    endcase
                end
            end
            ST_START: begin
                if (i_sts.empty) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_status = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_cmd.take_line = 1'b1;
                    n_state = ST_BYTES;
                end
            end
            ST_BYTES: begin
                if (i_sts.out_free) begin
                    if (i_sts.len_zero) begin
                        o_cmd.emit_zero = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.emit_byte = 1'b1;
                        if (i_sts.byte_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/lfq_dp.sv =====
// Datapath: line assembly, line memory, slot ring and output register.
`timescale 1ns / 1ps
`include "line_framer_with_line_queue_assert.svh"
module lfq_dp #(
    parameter int LINE_MAX    = lfq_pkg::LINE_MAX_DEF,
    parameter int QUEUE_DEPTH = lfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lfq_pkg::t_cmd i_cmd,
    output lfq_pkg::t_sts o_sts,
    input  logic [7:0]    i_in_byte,
    input  logic [7:0]    i_pop_cap,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_out_byte,
    output logic [5:0]    o_line_length,
    output logic          o_last,
    output logic [2:0]    o_lines_queued
);
    import lfq_pkg::*;

    localparam int LINE_CAP  = LINE_MAX - 1;
    localparam int POS_W     = $clog2(LINE_MAX);
    localparam int SLOT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W     = SLOT_W;
    localparam int ADDR_W    = SLOT_W + POS_W;
    localparam int MEM_DEPTH = (QUEUE_DEPTH + 1) * (2 ** POS_W);
    localparam int LEN_DEPTH = QUEUE_DEPTH + 1;

    // Line bytes, one row per slot; the ring has one spare slot for assembly.
    logic [7:0]        r_line_mem [MEM_DEPTH];
    logic [POS_W-1:0]  r_len_mem  [LEN_DEPTH];
    logic [7:0]        r_rd_byte;
    logic [POS_W-1:0]  r_rd_len;

    logic [POS_W-1:0]  r_pos;
    logic              r_over;
    logic [SLOT_W-1:0] r_wr_slot;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [CNT_W-1:0]  r_count;
    logic              r_fault;

    logic [SLOT_W-1:0] r_cur_slot;
    logic [SLOT_W-1:0] n_cur_slot;
    logic [POS_W-1:0]  r_idx;
    logic [POS_W-1:0]  n_idx;
    logic [POS_W-1:0]  r_len;
    logic [7:0]        r_cap;

    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [7:0]        r_obyte;
    logic [5:0]        r_olen;
    logic              r_olast;
    logic [2:0]        r_oqueued;

    logic              w_is_nl;
    logic              w_is_cr;
    logic              w_store;
    logic              w_close_ok;
    logic [7:0]        w_len8;
    logic [7:0]        w_eff8;
    logic              w_emit;

    assign w_is_nl    = (i_in_byte == BYTE_NL);
    assign w_is_cr    = (i_in_byte == BYTE_CR);
    assign w_store    = i_cmd.rx && !w_is_nl && !w_is_cr && (r_pos < POS_W'(LINE_CAP));
    assign w_close_ok = (r_pos != '0) && !r_over && (r_count < CNT_W'(QUEUE_DEPTH));

    // Truncate to capacity-1 when a capacity is given.
    assign w_len8 = 8'(r_rd_len);
    assign w_eff8 = ((r_cap != 8'd0) && (w_len8 >= r_cap)) ? (r_cap - 8'd1) : w_len8;

    assign w_emit = i_cmd.emit_status || i_cmd.emit_zero || i_cmd.emit_byte;

    assign n_cur_slot = i_cmd.take_line ? r_rd_slot : r_cur_slot;
    assign n_idx      = i_cmd.take_line ? '0
                      : (i_cmd.emit_byte ? (r_idx + POS_W'(1)) : r_idx);

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.len_zero  = (r_len == '0);
    assign o_sts.byte_last = (({1'b0, r_idx} + (POS_W + 1)'(1)) == {1'b0, r_len});
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Line memory: one write port for assembly, one registered read port for pop.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_line_mem[{r_wr_slot, r_pos}] <= i_in_byte;
        end
        r_rd_byte <= r_line_mem[ADDR_W'({n_cur_slot, n_idx})];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rx && w_is_nl && w_close_ok) begin
            r_len_mem[r_wr_slot] <= r_pos;
        end
        r_rd_len <= r_len_mem[r_rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_over    <= 1'b0;
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_count   <= '0;
            r_fault   <= 1'b0;
        end else begin
            if (i_cmd.rx) begin
                if (w_is_nl) begin
                    if (w_close_ok) begin
                        r_wr_slot <= (r_wr_slot == SLOT_W'(QUEUE_DEPTH)) ? '0
                                   : r_wr_slot + SLOT_W'(1);
                        r_count   <= r_count + CNT_W'(1);
                    end
                    r_pos  <= '0;
                    r_over <= 1'b0;
                end else if (!w_is_cr) begin
                    if (w_store) begin
                        r_pos <= r_pos + POS_W'(1);
                    end else begin
                        r_over <= 1'b1;
                    end
                end
            end
            if (i_cmd.link) begin
                r_fault <= 1'b1;
            end
            if (i_cmd.take_line) begin
                r_rd_slot <= (r_rd_slot == SLOT_W'(QUEUE_DEPTH)) ? '0
                           : r_rd_slot + SLOT_W'(1);
                r_count   <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_slot <= n_cur_slot;
        r_idx      <= n_idx;
        if (i_cmd.pop_accept) begin
            r_cap <= i_pop_cap;
        end
        if (i_cmd.take_line) begin
            r_len <= POS_W'(w_eff8);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_status) begin
            r_kind    <= r_fault ? KIND_DOWN : KIND_NONE;
            r_obyte   <= 8'd0;
            r_olen    <= 6'd0;
            r_olast   <= 1'b1;
            r_oqueued <= 3'd0;
        end else if (i_cmd.emit_zero) begin
            r_kind    <= KIND_ZERO;
            r_obyte   <= 8'd0;
            r_olen    <= 6'd0;
            r_olast   <= 1'b1;
            r_oqueued <= 3'(r_count);
        end else if (i_cmd.emit_byte) begin
            r_kind    <= KIND_BYTE;
            r_obyte   <= r_rd_byte;
            r_olen    <= 6'(r_len);
            r_olast   <= o_sts.byte_last;
            r_oqueued <= 3'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_out_byte     = r_obyte;
    assign o_line_length  = r_olen;
    assign o_last         = r_olast;
    assign o_lines_queued = r_oqueued;

    `LFQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
    `LFQ_ASSERT_NOW(a_ring_slots, i_clk, i_rst_n, r_count != '0, r_wr_slot != r_rd_slot, "assembly slot overlaps a queued line")
    `LFQ_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, w_emit, o_sts.out_free, "result emitted over a held result")
    `LFQ_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, i_cmd.emit_byte, r_idx < r_len, "byte read past line length")

endmodule

// ===== rtl/core/line_framer_with_line_queue.sv =====
// Top level of the newline-delimited line framer with its queue of lines.
`timescale 1ns / 1ps
// Splits a received byte stream into lines at newline and queues up to QUEUE_DEPTH of them.
// Carriage returns are dropped; a line keeps at most LINE_MAX-1 bytes and a longer one is
// dropped at its newline, as are empty lines and lines closed while the queue is full.
// A receive or link-down item is handled in its accept cycle. A pop item is accepted, then
// the oldest line is looked up and one result is emitted per cycle while the output is
// free: its bytes, or a zero-length result; a pop on an empty queue emits its status in
// place of the lookup. The line memory's single registered read port sets that pace. One
// item is worked on at a time: no new item is accepted until a pop has handed all of its
// results to the output register. The line memory holds QUEUE_DEPTH+1 rows so a line can be
// assembled in place while the queue is full; it needs no clearing pass after reset.
module line_framer_with_line_queue #(
    parameter int LINE_MAX    = lfq_pkg::LINE_MAX_DEF,    // 2 .. 64
    parameter int QUEUE_DEPTH = lfq_pkg::QUEUE_DEPTH_DEF  // 1 .. 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [1:0] op, [9:2] in_byte, [17:10] pop_capacity
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [13:8] line_length,
                                        // [16:14] lines_queued
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    import lfq_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [7:0] w_out_byte;
    logic [5:0] w_line_length;
    logic [2:0] w_lines_queued;

    // Sequence item acceptance and pop steps.
    lfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tdata[1:0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Hold assembly state, line memory, slot ring and the output register.
    lfq_dp #(
        .LINE_MAX    (LINE_MAX),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_in_byte      (s_axis_tdata[9:2]),
        .i_pop_cap      (s_axis_tdata[17:10]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_kind         (m_axis_tuser),
        .o_out_byte     (w_out_byte),
        .o_line_length  (w_line_length),
        .o_last         (m_axis_tlast),
        .o_lines_queued (w_lines_queued)
    );

    // Pack result fields, zero-fill the top seven bits.
    assign m_axis_tdata = {7'd0, w_lines_queued, w_line_length, w_out_byte};

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the line framer and its queue of lines.
`timescale 1ns / 1ps
module tb;
    import lfq_pkg::*;

    // Block sizes, matching the defaults of the top level.
    localparam int LINE_MAX     = LINE_MAX_DEF;
    localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int LINE_CAP     = LINE_MAX - 1;

    // Run control: the tail covers the longest pop twice.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 2 * LINE_MAX + 8;
    localparam int STALL_CYCLES = 300;
    localparam int RANDOM_ITEMS = 60;   // per idle mix, three mixes
    localparam int MAX_REPORTS  = 10;

    // One output item as the block should present it.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [5:0] line_length;
        logic       last;
        logic [2:0] lines_queued;
    } line_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [1:0] op, [9:2] in_byte, [17:10] pop_capacity
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] out_byte, [13:8] line_length, [16:14] lines_queued
    logic [1:0]  m_axis_tuser;   // [1:0] kind
    logic        m_axis_tlast;

    line_framer_with_line_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Items waiting for the driver, and results waiting for the block.
    logic [23:0]  item_queue[$];
    line_result_t expected_lines[$];

    // Shadow of the framer: assembly line, line queue and fault latch.
    logic [7:0] asm_buf [LINE_CAP];
    int         asm_pos;
    bit         asm_over;
    logic [7:0] line_mem [QUEUE_DEPTH][LINE_CAP];
    int         line_len [QUEUE_DEPTH];
    int         rd_slot;
    int         wr_slot;
    int         used_lines;
    bit         link_down;

    // Idle mix and the long output stall.
    int snd_idle_pct;
    int rcv_idle_pct;
    int stall_kick;
    int stall_ack;
    int stall_left;

    // Bookkeeping.
    bit s_hold;
    int cycle_count;
    int items_done;
    int pops_done;
    int lines_dropped;
    int results_checked;
    int mismatches;
    int unexpected;
    int leftovers;

    // Free-running clock, 2 ns period.
    always #1 i_clk = ~i_clk;

    // Advance the shadow by one accepted item and queue the results it causes.
    task automatic predict_item(input logic [23:0] d);
        logic [1:0]   op;
        logic [7:0]   rx_byte;
        int           cap;
        int           len;
        int           r;
        line_result_t res;
        op      = d[1:0];
        rx_byte = d[9:2];
        cap     = int'(d[17:10]);
        if (op == OP_RX) begin
            if (rx_byte == BYTE_NL) begin
                // Close the line; keep it only if non-empty, in size and the queue has room.
                if (asm_pos != 0 && !asm_over && used_lines < QUEUE_DEPTH) begin
                    for (int i = 0; i < asm_pos; i++) line_mem[wr_slot][i] = asm_buf[i];
                    line_len[wr_slot] = asm_pos;
                    wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
                    used_lines++;
                end else begin
                    lines_dropped++;
                end
                asm_pos  = 0;
                asm_over = 0;
            end else if (rx_byte != BYTE_CR) begin
                if (asm_pos < LINE_CAP) begin
                    asm_buf[asm_pos] = rx_byte;
                    asm_pos++;
                end else begin
                    asm_over = 1;
                end
            end
        end else if (op == OP_LINK) begin
            link_down = 1;
        end else if (op == OP_POP) begin
            pops_done++;
            res = '0;
            res.last = 1'b1;
            if (used_lines == 0) begin
                res.kind = link_down ? KIND_DOWN : KIND_NONE;
                expected_lines.push_back(res);
            end else begin
                r   = rd_slot;
                len = line_len[r];
                if (cap != 0 && len >= cap) len = cap - 1;
                rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
                used_lines--;
                res.lines_queued = 3'(used_lines);
                if (len == 0) begin
                    res.kind = KIND_ZERO;
                    expected_lines.push_back(res);
                end else begin
                    for (int i = 0; i < len; i++) begin
                        res.kind        = KIND_BYTE;
                        res.out_byte    = line_mem[r][i];
                        res.line_length = 6'(len);
                        res.last        = (i + 1 == len);
                        expected_lines.push_back(res);
                    end
                end
            end
        end
    endtask

    // Driver: offer the next item at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        if (!s_hold) begin
            if (item_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                s_axis_tdata  <= item_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_hold = 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off when kicked.
    always @(negedge i_clk) begin
        if (stall_kick != stall_ack) begin
            stall_ack  = stall_kick;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Monitor: predict on every accepted input item, check every accepted output item.
    always @(posedge i_clk) begin
        line_result_t got;
        line_result_t want;
        cycle_count++;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_item(s_axis_tdata);
                s_hold = 0;
                items_done++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind         = m_axis_tuser;
                got.out_byte     = m_axis_tdata[7:0];
                got.line_length  = m_axis_tdata[13:8];
                got.last         = m_axis_tlast;
                got.lines_queued = m_axis_tdata[16:14];
                if (expected_lines.size() == 0) begin
                    unexpected++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display("%0t: unexpected result: kind %0d byte %02h len %0d",
                                 $realtime, got.kind, got.out_byte, got.line_length);
                end else begin
                    want = expected_lines.pop_front();
                    results_checked++;
                    if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                        got.line_length !== want.line_length || got.last !== want.last ||
                        got.lines_queued !== want.lines_queued) begin
                        mismatches++;
                        if (mismatches + unexpected <= MAX_REPORTS)
                            $display({"%0t: exp k%0d b%02h l%0d t%0d q%0d,",
                                      " got k%0d b%02h l%0d t%0d q%0d"},
                                     $realtime, want.kind, want.out_byte, want.line_length,
                                     want.last, want.lines_queued, got.kind, got.out_byte,
                                     got.line_length, got.last, got.lines_queued);
                    end
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[line_framer_with_line_queue] ERROR");
            $finish;
        end
    end

    function automatic logic [23:0] pack_item(logic [1:0] op, logic [7:0] rx_byte,
                                              logic [7:0] cap);
        return {6'd0, cap, rx_byte, op};
    endfunction

    // Push one line of random content, with stray carriage returns, closed by newline.
    task automatic send_line(input int len, output int pushed);
        logic [7:0] b;
        pushed = 0;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (b == BYTE_NL) b = 8'h20;
            if ($urandom_range(19) == 0) b = BYTE_CR;
            item_queue.push_back(pack_item(OP_RX, b, 8'($urandom_range(255))));
            pushed++;
        end
        if ($urandom_range(3) == 0) begin
            item_queue.push_back(pack_item(OP_RX, BYTE_CR, 8'($urandom_range(255))));
            pushed++;
        end
        item_queue.push_back(pack_item(OP_RX, BYTE_NL, 8'($urandom_range(255))));
        pushed++;
    endtask

    task automatic send_pop(input logic [7:0] cap);
        item_queue.push_back(pack_item(OP_POP, 8'($urandom_range(255)), cap));
    endtask

    // Hold until the driver has nothing left and every expected result has come.
    task automatic wait_drained();
        while (item_queue.size() != 0 || s_hold || expected_lines.size() != 0)
            @(negedge i_clk);
    endtask

    // Mostly well-formed lines and pops, with some noise and broken lines.
    task automatic run_random(input int n);
        int count;
        int sel;
        int len;
        int pushed;
        logic [7:0] cap;
        count = 0;
        while (count < n) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                len = $urandom_range(99);
                if (len < 5)       len = 0;
                else if (len < 85) len = $urandom_range(1, 10);
                else if (len < 93) len = $urandom_range(11, 40);
                else               len = $urandom_range(LINE_CAP - 5, LINE_CAP + 7);
                send_line(len, pushed);
                count += pushed;
            end else if (sel < 90) begin
                len = $urandom_range(99);
                if (len < 40)      cap = 8'd0;
                else if (len < 50) cap = 8'd1;
                else if (len < 60) cap = 8'd2;
                else if (len < 90) cap = 8'($urandom_range(3, 20));
                else               cap = 8'($urandom_range(21, 255));
                send_pop(cap);
                count++;
            end else if (sel < 95) begin
                // Unused op: ignored, does not count.
                item_queue.push_back(pack_item(OP_NOP, 8'($urandom_range(255)),
                                               8'($urandom_range(255))));
            end else begin
                // Broken line: bytes with no newline, merged into the next line.
                for (int i = 0; i < 3; i++)
                    item_queue.push_back(pack_item(OP_RX, 8'($urandom_range(255)),
                                                   8'($urandom_range(255))));
                count += 3;
            end
        end
    endtask

    initial begin
        int pushed;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        s_hold        = 0;
        asm_pos       = 0;
        asm_over      = 0;
        rd_slot       = 0;
        wr_slot       = 0;
        used_lines    = 0;
        link_down     = 0;
        stall_kick    = 0;
        stall_ack     = 0;
        stall_left    = 0;
        cycle_count   = 0;
        items_done    = 0;
        pops_done     = 0;
        lines_dropped = 0;
        results_checked = 0;
        mismatches    = 0;
        unexpected    = 0;
        leftovers     = 0;
        snd_idle_pct  = 10;
        rcv_idle_pct  = 51;

        // Hold reset, release at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, field extremes, CR drop, empty line, truncation cases.
        send_pop(8'd0);
        item_queue.push_back(pack_item(OP_RX, 8'h41, 8'hFF));
        item_queue.push_back(pack_item(OP_RX, 8'hFF, 8'h00));
        item_queue.push_back(pack_item(OP_RX, 8'h00, 8'hFF));
        item_queue.push_back(pack_item(OP_RX, BYTE_CR, 8'h00));
        item_queue.push_back(pack_item(OP_RX, 8'h42, 8'h00));
        item_queue.push_back(pack_item(OP_RX, BYTE_NL, 8'h00));
        item_queue.push_back(pack_item(OP_RX, BYTE_NL, 8'h00));   // empty line, dropped
        send_pop(8'd0);
        item_queue.push_back(pack_item(OP_RX, 8'h78, 8'h00));
        item_queue.push_back(pack_item(OP_RX, BYTE_NL, 8'h00));
        send_pop(8'd1);                                          // truncated to nothing
        item_queue.push_back(pack_item(OP_RX, 8'h79, 8'h00));
        item_queue.push_back(pack_item(OP_RX, 8'h7A, 8'h00));
        item_queue.push_back(pack_item(OP_RX, BYTE_NL, 8'h00));
        send_pop(8'd2);                                          // one byte kept
        item_queue.push_back(pack_item(OP_NOP, 8'hFF, 8'hFF));
        send_pop(8'hFF);
        item_queue.push_back(pack_item(OP_LINK, 8'hFF, 8'hFF));  // latch link fault
        send_pop(8'hFF);

        run_random(RANDOM_ITEMS);
        wait_drained();

        snd_idle_pct = 51;
        rcv_idle_pct = 10;
        run_random(RANDOM_ITEMS);
        wait_drained();

        // No idling; fill the queue (the fifth line is dropped), then hold off the
        // output for a long stretch while pops and bytes keep coming.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        for (int i = 0; i < QUEUE_DEPTH + 1; i++) send_line($urandom_range(4, 10), pushed);
        wait_drained();
        stall_kick++;
        for (int i = 0; i < QUEUE_DEPTH + 1; i++) send_pop(8'd0);
        send_line(8, pushed);
        wait_drained();

        run_random(RANDOM_ITEMS);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        leftovers = expected_lines.size();

        $display("tb: %0d items in, %0d pops, %0d lines dropped, %0d results checked",
                 items_done, pops_done, lines_dropped, results_checked);
        $display("tb: three idle mixes and one %0d-cycle output stall, %0d failures",
                 STALL_CYCLES, mismatches + unexpected + leftovers);
        if (mismatches == 0 && unexpected == 0 && leftovers == 0) begin
            $display("[line_framer_with_line_queue] OK");
        end else begin
            $display("[line_framer_with_line_queue] ERROR");
        end
        $finish;
    end

endmodule
